// File: hw/rtl/descriptor_table_allocator_unit_defines.svh
// Assertion macros shared by the descriptor table allocator RTL.
`ifndef DESCRIPTOR_TABLE_ALLOCATOR_UNIT_DEFINES_SVH
`define DESCRIPTOR_TABLE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define DTA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DTA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define DTA_ASSERT(lbl, prop, msg)
`define DTA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/dta_pkg.sv
// Types and constants of the descriptor table allocator.
package dta_pkg;

   localparam int unsigned SLOT_COUNT_DEF  = 64;
   localparam int unsigned HANDLE_BITS_DEF = 16;

   typedef enum logic [2:0] {
      MODE_ALLOC    = 3'd0,
      MODE_ALLOC_AT = 3'd1,
      MODE_FREE     = 3'd2,
      MODE_GET      = 3'd3,
      MODE_DUP      = 3'd4,
      MODE_DUP2     = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_INVAL  = 2'd1,
      STATUS_BADF   = 2'd2,
      STATUS_MFILE  = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  slot_index;
      logic [7:0]  target_index;
      logic [15:0] object_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  result_index;
      logic [15:0] handle_out;
      logic        is_open;
      logic [15:0] acquired_handle;
      logic [15:0] released_handle;
   } rsp_type;

endpackage

// File: hw/rtl/dta_find_free.sv
// Rotated priority encoder: first empty slot at or after the start index, wrapping.
module dta_find_free #(
   parameter int unsigned SLOT_COUNT = dta_pkg::SLOT_COUNT_DEF
) (
   input  logic [SLOT_COUNT-1:0]         occupied,
   input  logic [$clog2(SLOT_COUNT)-1:0] start_index,
   output logic                          found,
   output logic [$clog2(SLOT_COUNT)-1:0] found_index
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

   logic [SLOT_COUNT-1:0] free_vec;
   logic [SLOT_COUNT-1:0] upper_vec;
   logic [SLOT_COUNT-1:0] pick_vec;

   always_comb begin
      free_vec = ~occupied;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         upper_vec[i] = free_vec[i] && (IDX_W'(i) >= start_index);
      end
      // prefer slots at or after the start, else wrap to the lowest
      pick_vec = (|upper_vec) ? upper_vec : free_vec;
      found    = |free_vec;
      found_index = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (pick_vec[i]) begin
            found_index = IDX_W'(i);
         end
      end
   end

endmodule

// File: hw/rtl/descriptor_table_allocator_unit.sv
// Top level of the descriptor table allocator: slot memory, next-fit hint and control.
//
// Descriptor table allocator. Holds SLOT_COUNT slots, each empty or holding a
// nonzero object handle of HANDLE_BITS bits, and serves one transaction at a
// time on the req_ channel: alloc (next-fit from the search hint), alloc at an
// index, free, get, dup and dup2. Every transaction gives exactly one rsp_
// transaction carrying status, result index, the looked-up handle and the
// handles whose reference counts rise and fall. At acceptance the slot memory
// is read at the source and target indexes into registers (synchronous
// read); the execute state then decides, writes back and loads the output
// register. The next request is taken once the state is idle again, while
// the previous response may still wait in the output register; the execute
// state holds only while that register is still full and not being taken.
// An occupancy bitmap in flip-flops, cleared by reset, marks live slots, so
// the table is empty right after reset without a clearing pass; the same
// bitmap feeds a rotated priority encoder that finds the free slot.
`include "descriptor_table_allocator_unit_defines.svh"

module descriptor_table_allocator_unit #(
   parameter int unsigned SLOT_COUNT  = dta_pkg::SLOT_COUNT_DEF,
   parameter int unsigned HANDLE_BITS = dta_pkg::HANDLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dta_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
   localparam int unsigned HINT_W = $clog2(SLOT_COUNT + 1);

   // slot memory and occupancy
   logic [HANDLE_BITS-1:0] slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  occ_ff, occ_in;
   logic [HINT_W-1:0]      hint_ff, hint_in;

   dta_pkg::fsm_type       state_ff, state_in;
   dta_pkg::req_type       req_ff;
   logic [HANDLE_BITS-1:0] rd_src_ff, rd_dst_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   dta_pkg::rsp_type       rsp_data_ff;

   // execute-cycle decision
   dta_pkg::rsp_type       res;
   logic                   wr_en;
   logic                   wr_occ;
   logic [IDX_W-1:0]       wr_idx;
   logic [HANDLE_BITS-1:0] wr_data;
   logic                   hint_upd;
   logic [HINT_W-1:0]      hint_new;
   logic                   done;
   logic                   accept;

   logic                   src_ok, dst_ok, src_occ, dst_occ;
   logic [IDX_W-1:0]       src_i, dst_i;
   logic [HANDLE_BITS-1:0] h_in, h_src, h_dst, h_new;
   logic [IDX_W-1:0]       start_idx;
   logic                   found;
   logic [IDX_W-1:0]       found_idx;

   assign req_ready = (state_ff == dta_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == dta_pkg::FSM_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // start of the cyclic search; a hint at the table end wraps to slot zero
   assign start_idx = (hint_ff >= HINT_W'(SLOT_COUNT)) ? '0 : hint_ff[IDX_W-1:0];

   dta_find_free #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_find_free (
      .occupied    (occ_ff),
      .start_index (start_idx),
      .found       (found),
      .found_index (found_idx)
   );

   // read both indexes at acceptance, write back in the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_src_ff <= slot_mem[req_data.slot_index[IDX_W-1:0]];
         rd_dst_ff <= slot_mem[req_data.target_index[IDX_W-1:0]];
         req_ff    <= req_data;
      end
      if (done && wr_en) begin
         slot_mem[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      src_ok  = ({1'b0, req_ff.slot_index} < 9'(SLOT_COUNT));
      dst_ok  = ({1'b0, req_ff.target_index} < 9'(SLOT_COUNT));
      src_i   = req_ff.slot_index[IDX_W-1:0];
      dst_i   = req_ff.target_index[IDX_W-1:0];
      // an entry whose occupancy bit is clear reads as the empty handle
      src_occ = src_ok && occ_ff[src_i];
      dst_occ = dst_ok && occ_ff[dst_i];
      h_src   = src_occ ? rd_src_ff : '0;
      h_dst   = dst_occ ? rd_dst_ff : '0;
      h_in    = HANDLE_BITS'(req_ff.object_handle);
      h_new   = (req_ff.mode == dta_pkg::MODE_DUP) ? h_src : h_in;

      res      = '0;
      res.status = dta_pkg::STATUS_OK;
      wr_en    = 1'b0;
      wr_occ   = 1'b0;
      wr_idx   = src_i;
      wr_data  = h_new;
      hint_upd = 1'b0;
      hint_new = hint_ff;

      unique case (req_ff.mode)
         dta_pkg::MODE_ALLOC, dta_pkg::MODE_DUP: begin
            if (req_ff.mode == dta_pkg::MODE_DUP && !src_occ) begin
               res.status = dta_pkg::STATUS_BADF;
            end else if (req_ff.mode == dta_pkg::MODE_ALLOC && h_in == '0) begin
               res.status = dta_pkg::STATUS_INVAL;
            end else if (!found) begin
               res.status = dta_pkg::STATUS_MFILE;
            end else begin
               wr_en    = 1'b1;
               wr_occ   = 1'b1;
               wr_idx   = found_idx;
               hint_upd = 1'b1;
               hint_new = HINT_W'(found_idx) + HINT_W'(1);
               res.acquired_handle = 16'(h_new);
               res.result_index    = 6'(found_idx);
            end
         end
         dta_pkg::MODE_ALLOC_AT: begin
            if (h_in == '0) begin
               res.status = dta_pkg::STATUS_INVAL;
            end else if (!src_ok) begin
               res.status = dta_pkg::STATUS_BADF;
            end else begin
               wr_en  = 1'b1;
               wr_occ = 1'b1;
               res.released_handle = 16'(h_src);
               res.acquired_handle = 16'(h_in);
               res.result_index    = 6'(req_ff.slot_index);
            end
         end
         dta_pkg::MODE_FREE: begin
            if (!src_occ) begin
               res.status = dta_pkg::STATUS_BADF;
            end else begin
               // clear the occupancy bit only; the stale data is masked
               wr_occ = 1'b1;
               res.released_handle = 16'(h_src);
               if (HINT_W'(src_i) < hint_ff) begin
                  hint_upd = 1'b1;
                  hint_new = HINT_W'(src_i);
               end
            end
         end
         dta_pkg::MODE_GET: begin
            if (!src_ok) begin
               res.status = dta_pkg::STATUS_BADF;
            end else begin
               res.handle_out = 16'(h_src);
               res.is_open    = src_occ;
            end
         end
         dta_pkg::MODE_DUP2: begin
            if (!src_ok || !dst_ok || !src_occ) begin
               res.status = dta_pkg::STATUS_BADF;
            end else begin
               res.result_index = 6'(req_ff.target_index);
               if (src_i != dst_i) begin
                  wr_en   = 1'b1;
                  wr_occ  = 1'b1;
                  wr_idx  = dst_i;
                  wr_data = h_src;
                  res.released_handle = 16'(h_dst);
                  res.acquired_handle = 16'(h_src);
               end
            end
         end
         default: begin
            res.status = dta_pkg::STATUS_INVAL;
         end
      endcase
   end

   // occupancy, hint and output register next values
   always_comb begin
      occ_in       = occ_ff;
      hint_in      = hint_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (done) begin
         rsp_valid_in = 1'b1;
         if (wr_occ) begin
            occ_in[wr_idx] = wr_en;
         end
         if (hint_upd) begin
            hint_in = hint_new;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dta_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = dta_pkg::FSM_EXEC;
            end
         end
         dta_pkg::FSM_EXEC: begin
            if (done) begin
               state_in = dta_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = dta_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dta_pkg::FSM_IDLE;
         occ_ff       <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= res;
      end
   end

   // hint stays within the table, end included
   `DTA_ASSERT(a_hint_range, hint_ff <= HINT_W'(SLOT_COUNT), "search hint beyond table end")
   // reset leaves an empty table with the hint at zero
   `DTA_ASSERT_ALWAYS(a_reset_clear, reset |=> (occ_ff == '0 && hint_ff == '0), "table not cleared by reset")
   // a finished transaction always lands in the output register
   `DTA_ASSERT(a_done_rsp, done |=> rsp_valid_ff, "execute cycle ended without a response")
   // the encoder only reports slots that are empty
   `DTA_ASSERT(a_found_free, found |-> !occ_ff[found_idx], "encoder picked an occupied slot")
   // an accepted request enters the execute state in the next cycle
   `DTA_ASSERT(a_accept_exec, accept |=> (state_ff == dta_pkg::FSM_EXEC), "accepted request not executed")

endmodule
